### hdl/sbd_pkg.sv
// shared types, constants and arithmetic helpers for the sponge boundary damper
`default_nettype none

package sbd_pkg;

    localparam int TBL_IDX_W  = 6;
    localparam int TBL_VAL_W  = 17;
    localparam int POS_W      = 10;
    localparam int GRID_W     = 11;
    localparam int WIDTH_W    = 7;
    localparam int SAMPLE_W   = 32;
    localparam int PIPE_DEPTH = 4;

    localparam logic                 MODE_DAMP     = 1'b0;
    localparam logic                 MODE_TABLE_WR = 1'b1;
    localparam logic [TBL_VAL_W-1:0] ONE_Q16       = 17'h10000;
    localparam logic [GRID_W-1:0]    GRID_RESET    = 11'd1024;
    localparam logic [WIDTH_W-1:0]   WIDTH_RESET   = 7'd20;

    typedef enum logic [1:0] {
        REG_GRID_SIZE_X   = 2'd0,
        REG_GRID_SIZE_Y   = 2'd1,
        REG_GRID_SIZE_Z   = 2'd2,
        REG_SPONGE_WIDTH  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                        mode;
        logic [POS_W-1:0]            pos_x;
        logic [POS_W-1:0]            pos_y;
        logic [POS_W-1:0]            pos_z;
        logic signed [SAMPLE_W-1:0]  sample;
        logic [TBL_IDX_W-1:0]        table_index;
        logic [TBL_VAL_W-1:0]        table_value;
    } t_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  damped_sample;
        logic                        in_sponge;
    } t_result;

    typedef struct packed {
        t_reg_idx                    index;
        logic [GRID_W-1:0]           value;
    } t_cfg;

    // distance to the nearest face, mirrored side clamps at zero outside the grid
    function automatic logic [GRID_W-1:0] face_distance(input logic [POS_W-1:0] c,
                                                        input logic [GRID_W-1:0] n);
        logic [GRID_W-1:0] c_ext;
        logic [GRID_W-1:0] far_d;
        c_ext = GRID_W'(c);
        if ((n == '0) || (c_ext > (n - GRID_W'(1)))) begin
            far_d = '0;
        end else begin
            far_d = n - GRID_W'(1) - c_ext;
        end
        return (c_ext < far_d) ? c_ext : far_d;
    endfunction

    // q8.24 times unsigned q1.16 with floor shift
    function automatic logic signed [SAMPLE_W-1:0] scale_q16(
        input logic signed [SAMPLE_W-1:0] s,
        input logic [TBL_VAL_W-1:0]       f
    );
        logic signed [SAMPLE_W+TBL_VAL_W:0] p;
        p = s * $signed({1'b0, f});
        return $signed(p[SAMPLE_W+15:16]);
    endfunction

endpackage

`default_nettype wire

### hdl/sbd_stream_if.sv
// valid/ready channel carrying one payload type
`default_nettype none

interface sbd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/sbd_ram.sv
// generic ram: one write port, several registered read ports
`default_nettype none

module sbd_ram #(
    parameter int WIDTH    = 17,
    parameter int DEPTH    = 64,
    parameter int RD_PORTS = 1
) (
    input  wire logic                                                  i_clk,
    input  wire logic                                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]          i_wr_addr,
    input  wire logic [WIDTH-1:0]                                      i_wr_data,
    input  wire logic                                                  i_rd_en,
    input  wire logic [RD_PORTS-1:0][((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [RD_PORTS-1:0][WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    for (genvar p = 0; p < RD_PORTS; p++) begin : g_rd
        always_ff @(posedge i_clk) begin
            if (i_rd_en) begin
                o_rd_data[p] <= r_mem[i_rd_addr[p]];
            end
        end
    end

endmodule

`default_nettype wire

### hdl/sponge_boundary_damper_unit.sv
// sponge boundary damper: table-driven absorbing layer applied to streamed samples
// a damped result becomes valid once it has passed the ram read, x and y slots into the output slot
// throughput: one item per cycle while the output is not stalled; three table reads per item, split over two rams
// stall: four result slots (ram read, x, y, output) collapse bubbles independently
// reset: synchronous active low; clears valids, config returns to 1024 cube and width 20,
// table stays undefined
`default_nettype none

module sponge_boundary_damper_unit #(
    parameter int MAX_SPONGE = 64,
    parameter int MAX_DIM    = 1024
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sbd_stream_if.sink   i_item,
    sbd_stream_if.sink   i_cfg,
    sbd_stream_if.source o_result
);

    // table address width and a common width for the index range check
    localparam int AW = (MAX_SPONGE > 1) ? $clog2(MAX_SPONGE) : 1;
    localparam int IW = (AW > sbd_pkg::TBL_IDX_W) ? AW : sbd_pkg::TBL_IDX_W;
    localparam int CW = IW + 1;
    localparam int GW = sbd_pkg::GRID_W;

    localparam logic [16:0]  MAX_DIM_V = 17'(MAX_DIM);
    localparam logic [GW-1:0] MAX_SP_V = GW'(MAX_SPONGE);

    // configuration registers
    logic [GW-1:0]                 r_grid_x;
    logic [GW-1:0]                 r_grid_y;
    logic [GW-1:0]                 r_grid_z;
    logic [sbd_pkg::WIDTH_W-1:0]   r_width;

    // pipeline valids
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_vo;

    // pipeline payload
    logic signed [sbd_pkg::SAMPLE_W-1:0]  r1_sample;
    logic [2:0]                           r1_hit;
    logic signed [sbd_pkg::SAMPLE_W-1:0]  r2_sample;
    logic [2:0]                           r2_hit;
    logic [sbd_pkg::TBL_VAL_W-1:0]        r2_fy;
    logic [sbd_pkg::TBL_VAL_W-1:0]        r2_fz;
    logic signed [sbd_pkg::SAMPLE_W-1:0]  r3_sample;
    logic [2:0]                           r3_hit;
    logic [sbd_pkg::TBL_VAL_W-1:0]        r3_fz;
    logic signed [sbd_pkg::SAMPLE_W-1:0]  r_o_sample;
    logic                                 r_o_sponge;

    // stage enables, each slot moves when empty or when the next one moves
    logic en1;
    logic en2;
    logic en3;
    logic en_o;
    logic acc;
    logic is_damp;

    // face distances and sponge hits
    logic [GW-1:0] n_x;
    logic [GW-1:0] n_y;
    logic [GW-1:0] n_z;
    logic [GW-1:0] w_sat;
    logic [GW-1:0] dist_x;
    logic [GW-1:0] dist_y;
    logic [GW-1:0] dist_z;
    logic [2:0]    hit;

    // table write path
    logic [IW-1:0]                 idx_ext;
    logic                          idx_ok;
    logic                          tbl_we;
    logic [AW-1:0]                 tbl_wr_addr;
    logic [sbd_pkg::TBL_VAL_W-1:0] tbl_wr_data;

    // table read data (registered inside the rams)
    logic [1:0][sbd_pkg::TBL_VAL_W-1:0] ram_a_rd;
    logic [sbd_pkg::TBL_VAL_W-1:0]      ram_b_rd;

    // ---------------------------------------------------------------
    // handshake
    // ---------------------------------------------------------------
    assign en_o = !r_vo || o_result.ready;
    assign en3  = !r_v3 || en_o;
    assign en2  = !r_v2 || en3;
    assign en1  = !r_v1 || en2;

    assign i_item.ready = en1;
    assign i_cfg.ready  = 1'b1;

    assign acc     = i_item.valid && en1;
    assign is_damp = (i_item.data.mode == sbd_pkg::MODE_DAMP);

    // ---------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_x <= sbd_pkg::GRID_RESET;
            r_grid_y <= sbd_pkg::GRID_RESET;
            r_grid_z <= sbd_pkg::GRID_RESET;
            r_width  <= sbd_pkg::WIDTH_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                sbd_pkg::REG_GRID_SIZE_X:  r_grid_x <= i_cfg.data.value;
                sbd_pkg::REG_GRID_SIZE_Y:  r_grid_y <= i_cfg.data.value;
                sbd_pkg::REG_GRID_SIZE_Z:  r_grid_z <= i_cfg.data.value;
                sbd_pkg::REG_SPONGE_WIDTH: r_width  <= i_cfg.data.value[sbd_pkg::WIDTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // distance front end, feeds the ram read addresses directly
    // ---------------------------------------------------------------
    // grid sizes above the supported dimension clamp to it
    assign n_x = (17'(r_grid_x) > MAX_DIM_V) ? MAX_DIM_V[GW-1:0] : r_grid_x;
    assign n_y = (17'(r_grid_y) > MAX_DIM_V) ? MAX_DIM_V[GW-1:0] : r_grid_y;
    assign n_z = (17'(r_grid_z) > MAX_DIM_V) ? MAX_DIM_V[GW-1:0] : r_grid_z;

    // sponge width clamps to the table depth
    assign w_sat = (GW'(r_width) > MAX_SP_V) ? MAX_SP_V : GW'(r_width);

    assign dist_x = sbd_pkg::face_distance(i_item.data.pos_x, n_x);
    assign dist_y = sbd_pkg::face_distance(i_item.data.pos_y, n_y);
    assign dist_z = sbd_pkg::face_distance(i_item.data.pos_z, n_z);

    // width zero makes every compare fail, so damping is off
    assign hit[0] = dist_x < w_sat;
    assign hit[1] = dist_y < w_sat;
    assign hit[2] = dist_z < w_sat;

    // ---------------------------------------------------------------
    // table write: factors above one clamp, indexes past the depth drop
    // ---------------------------------------------------------------
    assign idx_ext     = IW'(i_item.data.table_index);
    assign idx_ok      = CW'(idx_ext) < CW'(MAX_SPONGE);
    assign tbl_we      = acc && !is_damp && idx_ok;
    assign tbl_wr_addr = idx_ext[AW-1:0];
    assign tbl_wr_data = (i_item.data.table_value > sbd_pkg::ONE_Q16) ?
                         sbd_pkg::ONE_Q16 : i_item.data.table_value;

    // two copies of the table, same writes; copy a serves x and y, copy b serves z.
    // a write lands at the accepting edge, so a damp in the next cycle reads it back.
    sbd_ram #(
        .WIDTH    (sbd_pkg::TBL_VAL_W),
        .DEPTH    (MAX_SPONGE),
        .RD_PORTS (2)
    ) u_tbl_a (
        .i_clk     (i_clk),
        .i_we      (tbl_we),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data),
        .i_rd_en   (en1),
        .i_rd_addr ({dist_y[AW-1:0], dist_x[AW-1:0]}),
        .o_rd_data (ram_a_rd)
    );

    sbd_ram #(
        .WIDTH    (sbd_pkg::TBL_VAL_W),
        .DEPTH    (MAX_SPONGE),
        .RD_PORTS (1)
    ) u_tbl_b (
        .i_clk     (i_clk),
        .i_we      (tbl_we),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data),
        .i_rd_en   (en1),
        .i_rd_addr (dist_z[AW-1:0]),
        .o_rd_data (ram_b_rd)
    );

    // ---------------------------------------------------------------
    // valid chain, table writes never enter it
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= acc && is_damp;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en_o) begin
                r_vo <= r_v3;
            end
        end
    end

    // ---------------------------------------------------------------
    // damping datapath: one multiply in each stage after the ram read, x then y then z
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_sample <= i_item.data.sample;
            r1_hit    <= hit;
        end
        if (en2) begin
            r2_sample <= r1_hit[0] ? sbd_pkg::scale_q16(r1_sample, ram_a_rd[0]) : r1_sample;
            r2_hit    <= r1_hit;
            r2_fy     <= ram_a_rd[1];
            r2_fz     <= ram_b_rd;
        end
        if (en3) begin
            r3_sample <= r2_hit[1] ? sbd_pkg::scale_q16(r2_sample, r2_fy) : r2_sample;
            r3_hit    <= r2_hit;
            r3_fz     <= r2_fz;
        end
        if (en_o) begin
            r_o_sample <= r3_hit[2] ? sbd_pkg::scale_q16(r3_sample, r3_fz) : r3_sample;
            r_o_sponge <= |r3_hit;
        end
    end

    assign o_result.valid              = r_vo;
    assign o_result.data.damped_sample = r_o_sample;
    assign o_result.data.in_sponge     = r_o_sponge;

endmodule

`default_nettype wire

### hdl/sbd_checker.sv
// port-level checks for the sponge boundary damper, bound to the top level
`default_nettype none

module sbd_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_in_mode,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire sbd_pkg::t_result i_out_data
);

    logic [2:0] r_pending;
    logic [2:0] n_pending;
    logic       in_damp;
    logic       out_xfer;

    assign in_damp  = i_in_valid && i_in_ready && (i_in_mode == sbd_pkg::MODE_DAMP);
    assign out_xfer = i_out_valid && i_out_ready;

    always_comb begin
        n_pending = r_pending;
        if (in_damp && !out_xfer) begin
            n_pending = r_pending + 3'd1;
        end else if (!in_damp && out_xfer) begin
            n_pending = r_pending - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // every result belongs to an accepted damp request
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> (r_pending != 3'd0))
        else $error("result without a pending damp request");

    // no more requests in flight than the pipeline holds
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'(sbd_pkg::PIPE_DEPTH))
        else $error("more damp requests in flight than slots");

    // an empty output means the pipeline can take input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with an empty output");

endmodule

bind sponge_boundary_damper_unit sbd_checker u_sbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_mode   (i_item.data.mode),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);

`default_nettype wire
